FILE: hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths and parameter defaults for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // field widths of one input word and one result word
    localparam int BASE_W = 63;
    localparam int EXP_W  = 63;
    localparam int MODF_W = 31;
    localparam int RES_W  = 31;

    // default datapath sizes
    localparam int MOD_BITS_DEF = 31;
    localparam int EXP_BITS_DEF = 63;

endpackage

FILE: hw/rtl/mexp_in_if.sv
// ----------------------------------------------------------------------------
// mexp_in_if
// Operand channel: base, exponent and modulus with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_in_if
    import mexp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    logic [MODF_W-1:0] modulus;

    modport source (output valid, output base, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base, input exponent, input modulus,
                    output ready);
endinterface

FILE: hw/rtl/mexp_out_if.sv
// ----------------------------------------------------------------------------
// mexp_out_if
// Result channel: result and error flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_out_if
    import mexp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result;
    logic             error;

    modport source (output valid, output result, output error, input ready);
    modport sink   (input valid, input result, input error, output ready);
endinterface

FILE: hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by square-and-multiply with a
// bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One word is in flight at a time. The base is first reduced bit-serially,
// then every one of the EXP_BITS exponent bits costs one modular square,
// plus one modular multiply when the bit is set; each of those scans the
// multiplier one bit per cycle. A zero modulus or zero exponent skips the
// reduction and goes straight to the done state. The reduction, squares
// and multiplies share one shift-add-reduce step. A finished result sits
// in an output register, so the next word is taken while it waits. A zero
// modulus gives error = 1 and result 0; a zero exponent gives 1 for any
// other modulus.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_in_if.sink     i_in,
    mexp_out_if.source  o_out
);

    localparam int T_W   = MOD_BITS + 2;
    localparam int SH_W  = BASE_W;
    localparam int CNT_W = $clog2(SH_W);
    localparam int EC_W  = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [MOD_BITS-1:0] r_mod;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_bred;
    logic [MOD_BITS-1:0] r_prod;
    logic [SH_W-1:0]     r_sh;
    logic [CNT_W-1:0]    r_cnt;
    logic [EXP_BITS-1:0] r_exp;
    logic [EC_W-1:0]     r_exp_cnt;
    logic                r_err;
    logic                r_out_valid;
    logic [RES_W-1:0]    r_result;
    logic                r_error;

    logic [MOD_BITS-1:0] w_mod_in;
    logic [EXP_BITS-1:0] w_exp_in;
    logic [T_W-1:0]      w_addend;
    logic [T_W-1:0]      w_t;
    logic [T_W-1:0]      w_t1;
    logic [T_W-1:0]      w_t2;
    logic [MOD_BITS-1:0] n_prod;
    logic                w_accept;
    logic                w_load_out;

    // operands cut to the datapath sizes
    assign w_mod_in = MOD_BITS'(i_in.modulus);
    assign w_exp_in = EXP_BITS'(i_in.exponent);

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // shift-add step: t = 2*prod + digit, then remove m or 2m
    always_comb begin
        if (r_state == S_REDUCE) begin
            w_addend = T_W'(r_sh[SH_W-1]);
        end else if (r_sh[SH_W-1]) begin
            w_addend = (r_state == S_MULT) ? T_W'(r_bred) : T_W'(r_acc);
        end else begin
            w_addend = '0;
        end
        w_t  = (T_W'(r_prod) << 1) + w_addend;
        w_t1 = w_t - T_W'(r_mod);
        w_t2 = w_t - (T_W'(r_mod) << 1);
        priority if (!w_t2[T_W-1]) begin
            n_prod = MOD_BITS'(w_t2);
        end else if (!w_t1[T_W-1]) begin
            n_prod = MOD_BITS'(w_t1);
        end else begin
            n_prod = MOD_BITS'(w_t);
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_result    <= RES_W'(r_acc);
                r_error     <= r_err;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mod     <= w_mod_in;
                        r_exp     <= w_exp_in;
                        r_exp_cnt <= EC_W'(EXP_BITS - 1);
                        r_sh      <= i_in.base;
                        r_prod    <= '0;
                        r_cnt     <= CNT_W'(SH_W - 1);
                        r_err     <= 1'b0;
                        priority if (w_mod_in == '0) begin
                            r_acc   <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else if (w_exp_in == '0) begin
                            r_acc   <= MOD_BITS'(1);
                            r_state <= S_DONE;
                        end else begin
                            r_acc   <= (w_mod_in == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                            r_state <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    r_prod <= n_prod;
                    r_sh   <= r_sh << 1;
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        // reduced base ready, start the first square
                        r_bred  <= n_prod;
                        r_prod  <= '0;
                        r_sh    <= {r_acc, {(SH_W-MOD_BITS){1'b0}}};
                        r_cnt   <= CNT_W'(MOD_BITS - 1);
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE, S_MULT: begin
                    r_prod <= n_prod;
                    r_sh   <= r_sh << 1;
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_acc  <= n_prod;
                        r_prod <= '0;
                        r_sh   <= {n_prod, {(SH_W-MOD_BITS){1'b0}}};
                        r_cnt  <= CNT_W'(MOD_BITS - 1);
                        priority if ((r_state == S_SQUARE) && r_exp[EXP_BITS-1]) begin
                            r_state <= S_MULT;
                        end else if (r_exp_cnt == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            // next exponent bit
                            r_exp     <= r_exp << 1;
                            r_exp_cnt <= r_exp_cnt - EC_W'(1);
                            r_state   <= S_SQUARE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_result;
    assign o_out.error  = r_error;

    // partial remainder always stays below the modulus
    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE || r_state == S_SQUARE || r_state == S_MULT)
            |-> (r_prod < r_mod))
        else $error("partial remainder not reduced");

    // reduced base below the modulus while it is used
    a_base_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQUARE || r_state == S_MULT) |-> (r_bred < r_mod))
        else $error("reduced base out of range");

    // an error word carries a zero result
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error) |-> (o_out.result == '0))
        else $error("error word with nonzero result");

    // an accepted word leaves idle at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted word not started");

endmodule

FILE: tb/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking testbench for the modular exponentiation block: operand
// words are pushed through the input channel with random gaps, each accepted
// word is run through a square-and-multiply predictor, and every result word
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation
    import mexp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [BASE_W-1:0] BASE_MAX = '1;
    localparam logic [EXP_W-1:0]  EXP_MAX  = '1;
    localparam logic [MODF_W-1:0] MOD_MAX  = '1;

    typedef struct packed {
        logic [RES_W-1:0] result;
        logic             error;
    } t_result_word;

    logic clk;
    logic rst_n;

    mexp_in_if  in_ch ();
    mexp_out_if out_ch ();

    t_result_word pending_results[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;

    modular_exponentiation dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run length guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // square-and-multiply from the top exponent bit down
    function automatic t_result_word mod_pow(input logic [BASE_W-1:0] b,
                                             input logic [EXP_W-1:0]  e,
                                             input logic [MODF_W-1:0] m);
        t_result_word r;
        logic [63:0]  acc;
        logic [63:0]  red_base;
        r.error  = 1'b0;
        r.result = '0;
        if (m == '0) begin
            r.error = 1'b1;
        end else if (e == '0) begin
            r.result = RES_W'(1);
        end else begin
            red_base = 64'(b) % 64'(m);
            acc      = 64'd1 % 64'(m);
            for (int i = EXP_W - 1; i >= 0; i--) begin
                acc = (acc * acc) % 64'(m);
                if (e[i])
                    acc = (acc * red_base) % 64'(m);
            end
            r.result = acc[RES_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk) begin
        t_result_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", 64'(out_ch.result), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.result !== want.result)
                    report_mismatch("result", 64'(out_ch.result), 64'(want.result));
                if (out_ch.error !== want.error)
                    report_mismatch("error", 64'(out_ch.error), 64'(want.error));
            end
        end
    end

    // result side backpressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // drive one operand word, holding it until accepted; valid stays high
    task automatic send_word(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
                             input logic [MODF_W-1:0] m);
        bit dropped;
        dropped = 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            if (!dropped)
                in_ch.valid <= 1'b0;
            dropped = 1'b1;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.base     <= b;
        in_ch.exponent <= e;
        in_ch.modulus  <= m;
        do @(posedge clk); while (!in_ch.ready);
        pending_results.insert(pending_results.size(), mod_pow(b, e, m));
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(9))
            0:       return '0;
            1:       return BASE_W'($urandom_range(20));
            2:       return BASE_MAX;
            default: return BASE_W'(rand64());
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] pick_exponent();
        case ($urandom_range(11))
            0:       return '0;
            1:       return EXP_W'($urandom_range(1, 8));
            2:       return EXP_MAX;
            default: return EXP_W'(rand64());
        endcase
    endfunction

    function automatic logic [MODF_W-1:0] pick_modulus();
        case ($urandom_range(15))
            0:       return '0;
            1:       return MODF_W'(1);
            2, 3:    return MODF_W'($urandom_range(2, 40));
            4:       return MOD_MAX - MODF_W'($urandom_range(20));
            default: return MODF_W'($urandom);
        endcase
    endfunction

    // zero modulus, zero exponent, modulus one, zero base
    task automatic test_special_cases();
        send_word(63'd5, 63'd3, '0);
        send_word('0, '0, '0);
        send_word(BASE_MAX, EXP_MAX, '0);
        send_word(63'd7, '0, 31'd1);
        send_word('0, '0, 31'd13);
        send_word(BASE_MAX, '0, MOD_MAX);
        send_word(63'd12345, 63'd9, 31'd1);
        send_word(BASE_MAX, EXP_MAX, 31'd1);
        send_word('0, 63'd5, 31'd97);
        send_word('0, EXP_MAX, MOD_MAX);
    endtask

    // field extremes and base reduction
    task automatic test_operand_extremes();
        send_word(BASE_MAX, EXP_MAX, MOD_MAX);
        send_word(BASE_MAX, 63'd1, MOD_MAX);
        send_word(63'd2, 63'd30, MOD_MAX);
        send_word(63'(MOD_MAX), 63'd5, MOD_MAX);
        send_word(63'(MOD_MAX) * 63'd3, 63'd7, MOD_MAX);
        send_word(63'(MOD_MAX) - 63'd1, 63'd2, MOD_MAX);
        send_word(BASE_MAX, EXP_MAX, 31'd2);
        send_word(63'd1, EXP_MAX, MOD_MAX);
        send_word(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 31'h2AAA_AAAB);
        send_word(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 31'h5555_5555);
        send_word(63'd3, 63'd1, 31'd2);
        send_word(BASE_MAX, 63'd2, 31'd3);
    endtask

    // random operand words under the given idling mix
    task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int n = 0; n < count; n++)
            send_word(pick_base(), pick_exponent(), pick_modulus());
    endtask

    // sender holds off until the block has drained, then resumes
    task automatic test_drain_pause();
        for (int n = 0; n < 4; n++)
            send_word(pick_base(), pick_exponent(), pick_modulus());
        wait_all_results();
        for (int n = 0; n < 4; n++)
            send_word(pick_base(), pick_exponent(), pick_modulus());
    endtask

    // test sequence
    initial begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.base        <= '0;
        in_ch.exponent    <= '0;
        in_ch.modulus     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_operand_extremes();
        test_random_traffic(37, 30, 83);
        test_drain_pause();
        test_random_traffic(37, 83, 30);
        test_random_traffic(37, 0, 0);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_in_if.sv
hw/rtl/mexp_out_if.sv
hw/rtl/modular_exponentiation.sv
tb/tb_modular_exponentiation.sv
